// ----- rtl/cbbb_pkg.sv -----
// Shared constants and register map for the colour blob bounding box block.
package cbbb_pkg;

  localparam int unsigned DimW   = 11;
  localparam int unsigned FloorW = 8;
  localparam int unsigned CountW = 19;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned EdgeW  = 11;
  localparam int unsigned SizeW  = 10;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 80;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned RegDataW = 32;

  localparam logic [1:0] RegFrameWidth  = 2'd0;
  localparam logic [1:0] RegFrameHeight = 2'd1;
  localparam logic [1:0] RegRedFloor    = 2'd2;
  localparam logic [1:0] RegMinCount    = 2'd3;

  localparam logic [DimW-1:0]   FrameWidthRst  = 11'd320;
  localparam logic [DimW-1:0]   FrameHeightRst = 11'd240;
  localparam logic [FloorW-1:0] RedFloorRst    = 8'd80;
  localparam logic [CountW-1:0] MinCountRst    = 19'd15;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

endpackage

// ----- rtl/color_blob_bounding_box_top.sv -----
// Top level: red blob bounding box over a raster RGB pixel stream.
// The frame result is loaded into the output register as the last pixel is taken, and is valid in the cycle after.
// Throughput: one pixel per cycle; input stalls only while an unread result blocks the output.
// All work for a pixel is one pass of compare and min/max logic into the state registers.
// Reset (rst_ni low, asynchronous) clears position, accumulators and output valid, and loads
// the register defaults: width 320, height 240, red floor 80, minimum count 15.
module color_blob_bounding_box_top #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: red [7:0], green [15:8], blue [23:16]
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cbbb_pkg::InDataW-1:0]   s_axis_tdata,
  // tdata: pixel_count [18:0], left_edge [29:19], right_edge [40:30], blob_size [50:41],
  //        center_x [61:51], center_y [72:62], zero fill [79:73]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cbbb_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: detected [0]
  output logic                           m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cbbb_pkg::AddrW-1:0]     paddr,
  input  logic [cbbb_pkg::RegDataW-1:0]  pwdata,
  output logic [cbbb_pkg::RegDataW-1:0]  prdata,
  output logic                           pready
);
  import cbbb_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_DIM);
  localparam int unsigned CmpW = ($clog2(MAX_DIM + 1) > DimW) ? $clog2(MAX_DIM + 1) : DimW;

  // configuration registers
  logic [DimW-1:0]   frame_width_q, frame_height_q;
  logic [FloorW-1:0] red_floor_q;
  logic [CountW-1:0] min_count_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthRst;
      frame_height_q <= FrameHeightRst;
      red_floor_q    <= RedFloorRst;
      min_count_q    <= MinCountRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegFrameWidth:  frame_width_q  <= pwdata[DimW-1:0];
        RegFrameHeight: frame_height_q <= pwdata[DimW-1:0];
        RegRedFloor:    red_floor_q    <= pwdata[FloorW-1:0];
        RegMinCount:    min_count_q    <= pwdata[CountW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegFrameWidth:  prdata = RegDataW'(frame_width_q);
      RegFrameHeight: prdata = RegDataW'(frame_height_q);
      RegRedFloor:    prdata = RegDataW'(red_floor_q);
      RegMinCount:    prdata = RegDataW'(min_count_q);
      default:        prdata = '0;
    endcase
  end

  // effective frame size: zero acts as one, above MAX_DIM acts as MAX_DIM
  logic [CmpW-1:0] fw_raw, fh_raw, fw_eff, fh_eff;

  always_comb begin
    fw_raw = CmpW'(frame_width_q);
    fh_raw = CmpW'(frame_height_q);
    if (fw_raw == '0) begin
      fw_eff = CmpW'(1);
    end else if (fw_raw > CmpW'(MAX_DIM)) begin
      fw_eff = CmpW'(MAX_DIM);
    end else begin
      fw_eff = fw_raw;
    end
    if (fh_raw == '0) begin
      fh_eff = CmpW'(1);
    end else if (fh_raw > CmpW'(MAX_DIM)) begin
      fh_eff = CmpW'(MAX_DIM);
    end else begin
      fh_eff = fh_raw;
    end
  end

  // per-frame state
  logic [PosW-1:0]   column_q, row_q;
  logic [CountW-1:0] count_q, count_d;
  logic              seen_q;
  logic [PosW-1:0]   lcol_q, gcol_q, lrow_q, grow_q;
  logic [PosW-1:0]   lcol_d, gcol_d, lrow_d, grow_d;

  logic [ChanW-1:0] red, green, blue;
  logic             in_acc, hit, last_col, last_row, frame_end;

  assign red   = s_axis_tdata[ChanW-1:0];
  assign green = s_axis_tdata[2*ChanW-1:ChanW];
  assign blue  = s_axis_tdata[3*ChanW-1:2*ChanW];

  logic out_valid_q;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign last_col  = CmpW'(column_q) >= (fw_eff - CmpW'(1));
  assign last_row  = CmpW'(row_q) >= (fh_eff - CmpW'(1));
  assign frame_end = last_col && last_row;

  assign hit = !column_q[0] && !row_q[0] && (red > red_floor_q) && (red > green)
               && (red > blue);

  always_comb begin
    count_d = count_q;
    lcol_d  = lcol_q;
    gcol_d  = gcol_q;
    lrow_d  = lrow_q;
    grow_d  = grow_q;
    if (hit) begin
      if (count_q != CountMax) begin
        count_d = count_q + CountW'(1);
      end
      if (!seen_q || column_q < lcol_q) begin
        lcol_d = column_q;
      end
      if (column_q > gcol_q) begin
        gcol_d = column_q;
      end
      if (!seen_q || row_q < lrow_q) begin
        lrow_d = row_q;
      end
      if (row_q > grow_q) begin
        grow_d = row_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
      count_q  <= '0;
      seen_q   <= 1'b0;
      lcol_q   <= '1;
      gcol_q   <= '0;
      lrow_q   <= '1;
      grow_q   <= '0;
    end else if (in_acc) begin
      if (frame_end) begin
        column_q <= '0;
        row_q    <= '0;
        count_q  <= '0;
        seen_q   <= 1'b0;
        lcol_q   <= '1;
        gcol_q   <= '0;
        lrow_q   <= '1;
        grow_q   <= '0;
      end else begin
        if (last_col) begin
          column_q <= '0;
          row_q    <= row_q + PosW'(1);
        end else begin
          column_q <= column_q + PosW'(1);
        end
        count_q <= count_d;
        seen_q  <= seen_q | hit;
        lcol_q  <= lcol_d;
        gcol_q  <= gcol_d;
        lrow_q  <= lrow_d;
        grow_q  <= grow_d;
      end
    end
  end

  // frame result
  logic             det;
  logic [PosW:0]    span, sum_col, sum_row;
  logic [EdgeW-1:0] left_edge, right_edge, center_x, center_y;
  logic [SizeW-1:0] blob_size;

  assign det     = count_d > min_count_q;
  assign span    = ({1'b0, gcol_d} - {1'b0, lcol_d}) + ({1'b0, grow_d} - {1'b0, lrow_d});
  assign sum_col = {1'b0, lcol_d} + {1'b0, gcol_d};
  assign sum_row = {1'b0, lrow_d} + {1'b0, grow_d};

  always_comb begin
    if (det) begin
      left_edge  = EdgeW'(lcol_d);
      right_edge = EdgeW'(gcol_d);
      blob_size  = SizeW'(span[PosW:1]);
      center_x   = EdgeW'(sum_col[PosW:1]);
      center_y   = EdgeW'(sum_row[PosW:1]);
    end else begin
      left_edge  = '1;
      right_edge = '1;
      blob_size  = '0;
      center_x   = '1;
      center_y   = '1;
    end
  end

  logic [OutDataW-1:0] out_data_q;
  logic                out_det_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && frame_end) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && frame_end) begin
      out_det_q  <= det;
      out_data_q <= OutDataW'({center_y, center_x, blob_size, right_edge, left_edge, count_d});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_det_q;

endmodule

// ----- rtl/cbbb_checker.sv -----
// Port-level checker for the colour blob bounding box block, with its bind.
module cbbb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [cbbb_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                           m_axis_tuser
);

  // word held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

  // a new result needs a pixel taken the cycle before
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready)) |=> !m_axis_tvalid)
    else $error("result word appeared without a pixel");

  a_no_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |->
      (m_axis_tdata[29:19] == '1 && m_axis_tdata[40:30] == '1 && m_axis_tdata[50:41] == '0
       && m_axis_tdata[61:51] == '1 && m_axis_tdata[72:62] == '1))
    else $error("box fields wrong with no detection");

  a_detect_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[18:0] != '0))
    else $error("detection with zero count");

endmodule

bind color_blob_bounding_box_top cbbb_checker u_cbbb_checker (.*);

// ----- bench/color_blob_bounding_box_checker.sv -----
// Checker for the colour blob bounding box block: tracks registers, predicts frame words, compares.
`timescale 1ns / 100ps

module color_blob_bounding_box_checker #(
  parameter int unsigned MaxDim = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [cbbb_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [cbbb_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                          m_tuser_i,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [cbbb_pkg::AddrW-1:0]    paddr_i,
  input  logic [cbbb_pkg::RegDataW-1:0] pwdata_i,
  input  logic                          pready_i,
  output int                            errors_o,
  output int                            pending_o,
  output int                            frames_o,
  output int                            blobs_o
);
  import cbbb_pkg::*;

  typedef struct packed {
    logic               detected;
    logic [CountW-1:0]  count;
    logic [EdgeW-1:0]   left_edge;
    logic [EdgeW-1:0]   right_edge;
    logic [SizeW-1:0]   blob_size;
    logic [EdgeW-1:0]   center_x;
    logic [EdgeW-1:0]   center_y;
  } blob_report_t;

  logic [DimW-1:0]   width_q;
  logic [DimW-1:0]   height_q;
  logic [FloorW-1:0] floor_q;
  logic [CountW-1:0] min_count_q;

  int unsigned col, row, red_count;
  int unsigned least_col, greatest_col, least_row, greatest_row;
  int fails, frames, blobs;

  blob_report_t reports[$];

  function automatic int unsigned eff_dim(input logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic int field_bad(input string name, input int unsigned want,
                                   input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic clear_frame();
    col          = 0;
    row          = 0;
    red_count    = 0;
    least_col    = 32'hFFFF_FFFF;
    greatest_col = 0;
    least_row    = 32'hFFFF_FFFF;
    greatest_row = 0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [RegDataW-1:0] data);
    case (idx)
      RegFrameWidth: begin
        width_q = data[DimW-1:0];
      end
      RegFrameHeight: begin
        height_q = data[DimW-1:0];
      end
      RegRedFloor: begin
        floor_q = data[FloorW-1:0];
      end
      RegMinCount: begin
        min_count_q = data[CountW-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic step_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                            input logic [ChanW-1:0] b);
    int unsigned w, h, span, mid_x, mid_y;
    blob_report_t rep;
    w = eff_dim(width_q);
    h = eff_dim(height_q);
    if (col % 2 == 0 && row % 2 == 0 && r > floor_q && r > g && r > b) begin
      if (red_count < CountMax) red_count++;
      if (col < least_col) least_col = col;
      if (col > greatest_col) greatest_col = col;
      if (row < least_row) least_row = row;
      if (row > greatest_row) greatest_row = row;
    end
    if (col < w - 1) begin
      col++;
    end else if (row < h - 1) begin
      col = 0;
      row++;
    end else begin
      rep.detected = red_count > min_count_q;
      rep.count    = red_count[CountW-1:0];
      if (rep.detected) begin
        span           = (greatest_col - least_col) + (greatest_row - least_row);
        mid_x          = (least_col + greatest_col) >> 1;
        mid_y          = (least_row + greatest_row) >> 1;
        rep.left_edge  = least_col[EdgeW-1:0];
        rep.right_edge = greatest_col[EdgeW-1:0];
        rep.blob_size  = span[SizeW:1];
        rep.center_x   = mid_x[EdgeW-1:0];
        rep.center_y   = mid_y[EdgeW-1:0];
      end else begin
        rep.left_edge  = '1;
        rep.right_edge = '1;
        rep.blob_size  = '0;
        rep.center_x   = '1;
        rep.center_y   = '1;
      end
      reports.push_back(rep);
      clear_frame();
    end
  endtask

  task automatic check_report();
    blob_report_t want;
    if (reports.size() == 0) begin
      $error("result word with no frame pending");
      fails++;
    end else begin
      want = reports.pop_front();
      fails += field_bad("detected", want.detected, m_tuser_i);
      fails += field_bad("pixel_count", want.count, m_tdata_i[18:0]);
      fails += field_bad("left_edge", want.left_edge, m_tdata_i[29:19]);
      fails += field_bad("right_edge", want.right_edge, m_tdata_i[40:30]);
      fails += field_bad("blob_size", want.blob_size, m_tdata_i[50:41]);
      fails += field_bad("center_x", want.center_x, m_tdata_i[61:51]);
      fails += field_bad("center_y", want.center_y, m_tdata_i[72:62]);
      frames++;
      if (want.detected) blobs++;
    end
  endtask

  // results are popped before the new pixel is applied: a one-pixel frame can finish
  // on the same edge at which the previous word is taken; a register write lands after
  // the pixel taken on the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     = FrameWidthRst;
      height_q    = FrameHeightRst;
      floor_q     = RedFloorRst;
      min_count_q = MinCountRst;
      clear_frame();
      reports.delete();
      fails       = 0;
      frames      = 0;
      blobs       = 0;
      errors_o  <= 0;
      pending_o <= 0;
      frames_o  <= 0;
      blobs_o   <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_report();
      if (s_tvalid_i && s_tready_i) step_pixel(s_tdata_i[7:0], s_tdata_i[15:8], s_tdata_i[23:16]);
      if (psel_i && penable_i && pwrite_i && pready_i) write_reg(paddr_i[3:2], pwdata_i);
      errors_o  <= fails;
      pending_o <= reports.size();
      frames_o  <= frames;
      blobs_o   <= blobs;
    end
  end

endmodule

// ----- bench/color_blob_bounding_box_top_tb.sv -----
// Testbench top: pixel and register stimulus for the colour blob bounding box block, and verdict.
`timescale 1ns / 100ps

module color_blob_bounding_box_top_tb;
  import cbbb_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned RandomPixels = 550;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [RegDataW-1:0] pwdata = '0;
  logic [RegDataW-1:0] prdata;
  logic                pready;

  int errors, pending, frames, blobs;
  int unsigned cycles = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings = 0;
  int unsigned cur_floor = 80;
  bit sender_quiet = 1'b0;

  color_blob_bounding_box_top u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  color_blob_bounding_box_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_i(s_tready),
    .s_tdata_i (s_tdata),
    .m_tvalid_i(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_i (m_tdata),
    .m_tuser_i (m_tuser),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .pready_i  (pready),
    .errors_o  (errors),
    .pending_o (pending),
    .frames_o  (frames),
    .blobs_o   (blobs)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure: mostly short open stretches with occasional long ones, short and occasional long stalls
  initial begin
    int unsigned open_len, stall_len;
    @(posedge clk);
    forever begin
      open_len  = ($urandom_range(0, 99) < 20) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      stall_len = $urandom_range(0, 99);
      stall_len = (stall_len < 50) ? 0 : (stall_len < 85) ? $urandom_range(1, 3)
                                                            : $urandom_range(8, 40);
      m_tready <= 1'b1;
      repeat (open_len) @(posedge clk);
      if (stall_len > 0) begin
        m_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  function automatic int unsigned frame_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned w, input int unsigned h,
                            input int unsigned red_floor, input int unsigned min_cnt);
    write_reg(RegFrameWidth, w);
    write_reg(RegFrameHeight, h);
    write_reg(RegRedFloor, red_floor);
    write_reg(RegMinCount, min_cnt);
    cur_floor = red_floor;
    settings++;
  endtask

  task automatic push_pixel(input logic [InDataW-1:0] word);
    int unsigned gap, roll;
    roll = $urandom_range(0, 99);
    gap  = (sender_quiet || roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // sender stops until every frame word is back, then lets the block settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_pixels(input int unsigned count, input int unsigned red_pct);
    logic [7:0] r, g, b;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < red_pct) begin
        r = (cur_floor >= 255) ? 8'hFF : 8'($urandom_range(cur_floor + 1, 255));
        g = 8'($urandom_range(0, r - 1));
        b = 8'($urandom_range(0, r - 1));
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
      push_pixel({b, g, r});
    end
  endtask

  initial begin
    int unsigned w, h, red_floor, min_cnt, len, count, roll;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-pixel frames: colour comparisons at both floor extremes
    set_config(0, 0, 0, 0);
    push_pixel({8'h00, 8'h00, 8'hFF});
    push_pixel({8'h00, 8'h00, 8'h00});
    push_pixel({8'hFF, 8'hFF, 8'hFF});
    push_pixel({8'h00, 8'h00, 8'h01});
    push_pixel({8'hFE, 8'hFE, 8'hFF});
    push_pixel({8'h00, 8'hC8, 8'h80});
    push_pixel({8'hC8, 8'h00, 8'h80});
    drain();
    set_config(0, 0, 255, 19'h7FFFF);
    push_pixel({8'h00, 8'h00, 8'hFF});
    drain();

    // 3x3 frame, red just above and exactly at the floor
    set_config(3, 3, 80, 0);
    push_pixel({8'h00, 8'h00, 8'd81});
    push_pixel({8'h00, 8'h00, 8'hFF});
    push_pixel({8'h00, 8'h00, 8'd80});
    for (int i = 0; i < 6; i++) push_pixel({8'h10, 8'h20, 8'hF0});
    drain();

    // frame size shrunk mid-frame: width first, then height
    set_config(6, 6, 80, 1);
    for (int i = 0; i < 9; i++) push_pixel({8'h00, 8'h00, 8'hC0});
    drain();
    write_reg(RegFrameWidth, 2);
    for (int i = 0; i < 3; i++) push_pixel({8'h00, 8'h00, 8'hC0});
    drain();
    write_reg(RegFrameHeight, 1);
    for (int i = 0; i < 2; i++) push_pixel({8'h00, 8'h00, 8'hC0});
    drain();

    // random settings, mostly small frames; some phases stop mid-frame
    count = 0;
    while (count < RandomPixels) begin
      roll = $urandom_range(0, 99);
      w = (roll < 8) ? 0 : (roll < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      roll = $urandom_range(0, 99);
      h = (roll < 8) ? 0 : (roll < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
      roll = $urandom_range(0, 99);
      red_floor = (roll < 10) ? 0 : (roll < 20) ? 255 : $urandom_range(0, 200);
      roll = $urandom_range(0, 99);
      min_cnt = (roll < 60) ? $urandom_range(0, 3) : (roll < 85) ? $urandom_range(0, 64)
                                                                 : 19'h7FFFF;
      set_config(w, h, red_floor, min_cnt);
      len = frame_dim(w) * frame_dim(h);
      len = len * $urandom_range(1, 4) +
            (($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0);
      sender_quiet = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      run_pixels(len, (roll < 10) ? 0 : (roll < 20) ? 100 : $urandom_range(0, 100));
      count += len;
      drain();
    end

    // flush any partial frame, then the widest frame
    sender_quiet = 1'b0;
    set_config(0, 0, 80, 0);
    run_pixels(1, 50);
    drain();
    set_config(2047, 0, 80, 0);
    run_pixels(1024, 10);
    drain();
    repeat (10) @(posedge clk);

    $display("%0d pixels over %0d register settings; %0d frame words checked, %0d with a blob",
             pixels_sent, settings, frames, blobs);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cbbb_pkg.sv
rtl/color_blob_bounding_box_top.sv
rtl/cbbb_checker.sv
bench/color_blob_bounding_box_checker.sv
bench/color_blob_bounding_box_top_tb.sv
